// ----- rtl/flac_frame_header_parser_core_macros.svh -----
// Assertion macros for the checker file of the FLAC frame header parser.
// Depends on nothing; each macro expects clk and arst_n in scope.
`ifndef FLAC_FRAME_HEADER_PARSER_CORE_MACROS_SVH
`define FLAC_FRAME_HEADER_PARSER_CORE_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define FHP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication checked in the next cycle outside reset.
`define FHP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/flac_fhp_pkg.sv -----
// Types, status codes, tables and the CRC-8 step of the FLAC frame header parser.
// Depends on nothing; used by every module of the block.
package flac_fhp_pkg;

	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_SYNC      = 4'd1;
	localparam logic [3:0] ST_CHAN_MODE = 4'd2;
	localparam logic [3:0] ST_SAMPLE_SZ = 4'd3;
	localparam logic [3:0] ST_PADDING   = 4'd4;
	localparam logic [3:0] ST_UTF8      = 4'd5;
	localparam logic [3:0] ST_BLOCKSIZE = 4'd6;
	localparam logic [3:0] ST_RATE      = 4'd7;
	localparam logic [3:0] ST_CRC       = 4'd8;

	localparam logic [3:0] BC_INVALID = 4'd0;
	localparam logic [3:0] BC_8BIT    = 4'd6;
	localparam logic [3:0] BC_16BIT   = 4'd7;
	localparam logic [3:0] RC_KHZ     = 4'd12;
	localparam logic [3:0] RC_HZ      = 4'd13;
	localparam logic [3:0] RC_10HZ    = 4'd14;
	localparam logic [3:0] RC_INVALID = 4'd15;

	localparam logic [7:0] SYNC_BYTE0 = 8'hFF;
	localparam logic [6:0] SYNC_BYTE1 = 7'b1111100;
	localparam logic [7:0] CRC_POLY   = 8'h07;

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_SYNC1,
		PH_CODES,
		PH_CHAN,
		PH_LEAD,
		PH_CONT,
		PH_BS_HI,
		PH_BS_LO,
		PH_SR_HI,
		PH_SR_LO,
		PH_CRC
	} phase_t;

	// Codes and raw fields that the size and rate decoder needs.
	typedef struct packed {
		logic [3:0]  block_code;
		logic [3:0]  rate_code;
		logic [15:0] raw_block;
		logic [15:0] raw_rate;
	} hdr_codes_t;

	// One result of the parser, fields already zero on an error.
	typedef struct packed {
		logic        valid;
		logic [3:0]  status;
		logic        variable_size;
		logic [3:0]  channels;
		logic [1:0]  channel_mode;
		logic [4:0]  bits_per_sample;
		logic [35:0] number;
	} hdr_res_t;

	function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
		end
		return c;
	endfunction

	function automatic logic [4:0] bps_lookup(input logic [2:0] code);
		logic [4:0] v;
		case (code)
			3'd1:    v = 5'd8;
			3'd2:    v = 5'd12;
			3'd4:    v = 5'd16;
			3'd5:    v = 5'd20;
			3'd6:    v = 5'd24;
			default: v = 5'd0;
		endcase
		return v;
	endfunction

	function automatic logic [16:0] block_lookup(input logic [3:0] code);
		logic [16:0] v;
		case (code)
			4'd1:    v = 17'd192;
			4'd2:    v = 17'd576;
			4'd3:    v = 17'd1152;
			4'd4:    v = 17'd2304;
			4'd5:    v = 17'd4608;
			4'd8:    v = 17'd256;
			4'd9:    v = 17'd512;
			4'd10:   v = 17'd1024;
			4'd11:   v = 17'd2048;
			4'd12:   v = 17'd4096;
			4'd13:   v = 17'd8192;
			4'd14:   v = 17'd16384;
			4'd15:   v = 17'd32768;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	function automatic logic [19:0] rate_lookup(input logic [3:0] code);
		logic [19:0] v;
		case (code)
			4'd1:    v = 20'd88200;
			4'd2:    v = 20'd176400;
			4'd3:    v = 20'd192000;
			4'd4:    v = 20'd8000;
			4'd5:    v = 20'd16000;
			4'd6:    v = 20'd22050;
			4'd7:    v = 20'd24000;
			4'd8:    v = 20'd32000;
			4'd9:    v = 20'd44100;
			4'd10:   v = 20'd48000;
			4'd11:   v = 20'd96000;
			default: v = 20'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- rtl/flac_fhp_parse.sv -----
// Byte-wise header parser: phase, CRC-8, UTF-8 number and held header fields.
// Depends on flac_fhp_pkg.
module flac_fhp_parse (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step,
	input  logic [7:0]               data_byte,
	input  logic                     frame_start,
	output flac_fhp_pkg::hdr_res_t   res,
	output flac_fhp_pkg::hdr_codes_t codes
);
	import flac_fhp_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  crc_q, crc_d;
	logic [2:0]  left_q, left_d;
	logic [3:0]  bc_q, bc_d;
	logic [3:0]  rc_q, rc_d;
	logic [35:0] num_q, num_d;
	logic        var_q, var_d;
	logic [3:0]  chan_q, chan_d;
	logic [1:0]  mode_q, mode_d;
	logic [4:0]  bps_q, bps_d;
	logic [15:0] rawb_q, rawb_d;
	logic [15:0] rawr_q, rawr_d;

	logic        emit;
	logic [3:0]  st;
	logic [7:0]  crc_next;
	logic        an_err;
	logic [3:0]  an_st;
	phase_t      an_phase;
	phase_t      rate_phase;

	assign crc_next = crc8_step(frame_start ? 8'h00 : crc_q, data_byte);

	// Where the header goes once the number is complete.
	always_comb begin
		if (rc_q == RC_KHZ) begin
			rate_phase = PH_SR_LO;
		end else if (rc_q == RC_HZ || rc_q == RC_10HZ) begin
			rate_phase = PH_SR_HI;
		end else begin
			rate_phase = PH_CRC;
		end
		an_err = 1'b0;
		an_st = ST_OK;
		an_phase = rate_phase;
		if (bc_q == BC_INVALID) begin
			an_err = 1'b1;
			an_st = ST_BLOCKSIZE;
		end else if (rc_q == RC_INVALID) begin
			an_err = 1'b1;
			an_st = ST_RATE;
		end else if (bc_q == BC_8BIT) begin
			an_phase = PH_BS_LO;
		end else if (bc_q == BC_16BIT) begin
			an_phase = PH_BS_HI;
		end
	end

	always_comb begin
		phase_d = phase_q;
		crc_d = crc_q;
		left_d = left_q;
		bc_d = bc_q;
		rc_d = rc_q;
		num_d = num_q;
		var_d = var_q;
		chan_d = chan_q;
		mode_d = mode_q;
		bps_d = bps_q;
		rawb_d = rawb_q;
		rawr_d = rawr_q;
		emit = 1'b0;
		st = ST_OK;
		if (frame_start) begin
			crc_d = crc_next;
			bc_d = 4'd0;
			rc_d = 4'd0;
			num_d = 36'd0;
			left_d = 3'd0;
			rawb_d = 16'd0;
			rawr_d = 16'd0;
			if (data_byte != SYNC_BYTE0) begin
				emit = 1'b1;
				st = ST_SYNC;
			end else begin
				phase_d = PH_SYNC1;
			end
		end else if (phase_q != PH_IDLE) begin
			crc_d = crc_next;
			case (phase_q)
				PH_SYNC1: begin
					if (data_byte[7:1] != SYNC_BYTE1) begin
						emit = 1'b1;
						st = ST_SYNC;
					end else begin
						var_d = data_byte[0];
						phase_d = PH_CODES;
					end
				end
				PH_CODES: begin
					bc_d = data_byte[7:4];
					rc_d = data_byte[3:0];
					phase_d = PH_CHAN;
				end
				PH_CHAN: begin
					if (data_byte[7:4] >= 4'd11) begin
						emit = 1'b1;
						st = ST_CHAN_MODE;
					end else if (data_byte[3:1] == 3'd3 || data_byte[3:1] == 3'd7) begin
						emit = 1'b1;
						st = ST_SAMPLE_SZ;
					end else if (data_byte[0]) begin
						emit = 1'b1;
						st = ST_PADDING;
					end else begin
						if (!data_byte[7]) begin
							chan_d = data_byte[7:4] + 4'd1;
							mode_d = 2'd0;
						end else begin
							// Codes 8 to 10 are the stereo decorrelation modes.
							chan_d = 4'd2;
							mode_d = 2'(data_byte[7:4] - 4'd7);
						end
						bps_d = bps_lookup(data_byte[3:1]);
						phase_d = PH_LEAD;
					end
				end
				PH_LEAD: begin
					if (data_byte[7:6] == 2'b10 || data_byte == 8'hFF) begin
						emit = 1'b1;
						st = ST_UTF8;
					end else if (!data_byte[7]) begin
						num_d = {28'd0, data_byte};
						emit = an_err;
						st = an_st;
						phase_d = an_phase;
					end else begin
						if (data_byte[5] == 1'b0) begin
							left_d = 3'd1;
							num_d = {31'd0, data_byte[4:0]};
						end else if (data_byte[4] == 1'b0) begin
							left_d = 3'd2;
							num_d = {32'd0, data_byte[3:0]};
						end else if (data_byte[3] == 1'b0) begin
							left_d = 3'd3;
							num_d = {33'd0, data_byte[2:0]};
						end else if (data_byte[2] == 1'b0) begin
							left_d = 3'd4;
							num_d = {34'd0, data_byte[1:0]};
						end else if (data_byte[1] == 1'b0) begin
							left_d = 3'd5;
							num_d = {35'd0, data_byte[0]};
						end else begin
							left_d = 3'd6;
							num_d = 36'd0;
						end
						phase_d = PH_CONT;
					end
				end
				PH_CONT: begin
					if (data_byte[7:6] != 2'b10) begin
						emit = 1'b1;
						st = ST_UTF8;
					end else begin
						num_d = {num_q[29:0], data_byte[5:0]};
						left_d = left_q - 3'd1;
						if (left_q == 3'd1) begin
							emit = an_err;
							st = an_st;
							phase_d = an_phase;
						end
					end
				end
				PH_BS_HI: begin
					rawb_d = {data_byte, 8'h00};
					phase_d = PH_BS_LO;
				end
				PH_BS_LO: begin
					rawb_d = {rawb_q[15:8], data_byte};
					phase_d = rate_phase;
				end
				PH_SR_HI: begin
					rawr_d = {data_byte, 8'h00};
					phase_d = PH_SR_LO;
				end
				PH_SR_LO: begin
					rawr_d = {rawr_q[15:8], data_byte};
					phase_d = PH_CRC;
				end
				PH_CRC: begin
					emit = 1'b1;
					st = (crc_next != 8'h00) ? ST_CRC : ST_OK;
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
		if (emit) begin
			phase_d = PH_IDLE;
		end
	end

	always_comb begin
		res.valid = step && emit;
		res.status = st;
		res.variable_size = (st == ST_OK) ? var_q : 1'b0;
		res.channels = (st == ST_OK) ? chan_q : 4'd0;
		res.channel_mode = (st == ST_OK) ? mode_q : 2'd0;
		res.bits_per_sample = (st == ST_OK) ? bps_q : 5'd0;
		res.number = (st == ST_OK) ? num_q : 36'd0;
		codes.block_code = bc_q;
		codes.rate_code = rc_q;
		codes.raw_block = rawb_q;
		codes.raw_rate = rawr_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			crc_q <= 8'h00;
			left_q <= 3'd0;
			bc_q <= 4'd0;
			rc_q <= 4'd0;
		end else if (step) begin
			phase_q <= phase_d;
			crc_q <= crc_d;
			left_q <= left_d;
			bc_q <= bc_d;
			rc_q <= rc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			num_q <= num_d;
			var_q <= var_d;
			chan_q <= chan_d;
			mode_q <= mode_d;
			bps_q <= bps_d;
			rawb_q <= rawb_d;
			rawr_q <= rawr_d;
		end
	end

endmodule

// ----- rtl/flac_fhp_decode.sv -----
// Turns the block size and sample rate codes and raw fields into sample counts and hertz.
// Depends on flac_fhp_pkg.
module flac_fhp_decode (
	input  flac_fhp_pkg::hdr_codes_t codes,
	output logic [16:0]              block_size,
	output logic [19:0]              rate_hz
);
	import flac_fhp_pkg::*;

	logic [25:0] khz_prod;
	logic [19:0] tenhz_prod;

	// Only the low 20 bits of the scaled rate are kept.
	assign khz_prod = 26'(codes.raw_rate) * 26'd1000;
	assign tenhz_prod = 20'(codes.raw_rate) * 20'd10;

	always_comb begin
		if (codes.block_code == BC_8BIT || codes.block_code == BC_16BIT) begin
			block_size = 17'(codes.raw_block) + 17'd1;
		end else begin
			block_size = block_lookup(codes.block_code);
		end
		case (codes.rate_code)
			RC_KHZ:     rate_hz = khz_prod[19:0];
			RC_HZ:      rate_hz = 20'(codes.raw_rate);
			RC_10HZ:    rate_hz = tenhz_prod;
			RC_INVALID: rate_hz = 20'd0;
			default:    rate_hz = rate_lookup(codes.rate_code);
		endcase
	end

endmodule

// ----- rtl/flac_frame_header_parser_core.sv -----
// Channel  | Signals                          | Item
// byte     | byte_valid, byte_stall           | data_byte, frame_start
// hdr      | hdr_valid, hdr_stall             | status and decoded header fields
//
// One byte per cycle while byte_stall is low: an accepted byte is held in the input register
// until the parse stage takes it, and any result it causes is loaded into the output register,
// so hdr_valid rises once the byte that ends a header has passed both of these registers.
// The parse stage advances whenever the output register is empty or is read in that cycle;
// when the output is stalled and full, the parse stage holds and byte_stall rises.
// Reset leaves the parser idle until a byte with frame_start set arrives.
// Depends on flac_fhp_pkg, flac_fhp_parse and flac_fhp_decode.
module flac_frame_header_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_stall,
	input  logic [7:0]  data_byte,
	input  logic        frame_start,
	output logic        hdr_valid,
	input  logic        hdr_stall,
	output logic [3:0]  status,
	output logic        variable_size,
	output logic [3:0]  channels,
	output logic [1:0]  channel_mode,
	output logic [4:0]  bits_per_sample,
	output logic [35:0] frame_or_sample_number,
	output logic [16:0] block_size,
	output logic [19:0] rate_hz
);
	import flac_fhp_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        start_s1;
	logic        advance;
	hdr_res_t    res;
	hdr_codes_t  codes;
	logic [16:0] dec_block;
	logic [19:0] dec_rate;
	logic        ok;

	logic        out_valid_q;
	logic [3:0]  status_q;
	logic        var_q;
	logic [3:0]  chan_q;
	logic [1:0]  mode_q;
	logic [4:0]  bps_q;
	logic [35:0] num_q;
	logic [16:0] block_q;
	logic [19:0] rate_q;

	assign advance = valid_s1 && (!out_valid_q || !hdr_stall);
	assign byte_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_valid && !byte_stall) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			byte_s1 <= data_byte;
			start_s1 <= frame_start;
		end
	end

	flac_fhp_parse u_parse (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.data_byte  (byte_s1),
		.frame_start(start_s1),
		.res        (res),
		.codes      (codes)
	);

	flac_fhp_decode u_decode (
		.codes      (codes),
		.block_size (dec_block),
		.rate_hz    (dec_rate)
	);

	assign ok = (res.status == ST_OK);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.valid) begin
			out_valid_q <= 1'b1;
		end else if (!hdr_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			status_q <= res.status;
			var_q <= res.variable_size;
			chan_q <= res.channels;
			mode_q <= res.channel_mode;
			bps_q <= res.bits_per_sample;
			num_q <= res.number;
			block_q <= ok ? dec_block : 17'd0;
			rate_q <= ok ? dec_rate : 20'd0;
		end
	end

	assign hdr_valid = out_valid_q;
	assign status = status_q;
	assign variable_size = var_q;
	assign channels = chan_q;
	assign channel_mode = mode_q;
	assign bits_per_sample = bps_q;
	assign frame_or_sample_number = num_q;
	assign block_size = block_q;
	assign rate_hz = rate_q;

endmodule

// ----- rtl/flac_fhp_checker.sv -----
// Port-level checks of the FLAC frame header parser, bound to the top level.
// Depends on flac_fhp_pkg and flac_frame_header_parser_core_macros.svh.
`include "flac_frame_header_parser_core_macros.svh"

module flac_fhp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        hdr_valid,
	input logic        hdr_stall,
	input logic [3:0]  status,
	input logic [3:0]  channels,
	input logic [1:0]  channel_mode,
	input logic [35:0] frame_or_sample_number,
	input logic [16:0] block_size,
	input logic [19:0] rate_hz
);
	import flac_fhp_pkg::*;

	logic is_ok;
	logic fields_clear;
	logic fields_set;

	assign is_ok = (status == ST_OK);
	assign fields_clear = channels == 4'd0 && block_size == 17'd0 && rate_hz == 20'd0
		&& frame_or_sample_number == 36'd0;
	assign fields_set = channels != 4'd0 && block_size != 17'd0;

	`FHP_ASSERT_NEXT(a_hdr_hold, hdr_valid && hdr_stall, hdr_valid, "result dropped while stalled")
	`FHP_ASSERT(a_status_range, !hdr_valid || status <= ST_CRC, "status out of range")
	`FHP_ASSERT(a_error_zero, !hdr_valid || is_ok || fields_clear, "error result carries fields")
	`FHP_ASSERT(a_ok_fields, !hdr_valid || !is_ok || fields_set, "good header with empty fields")
	`FHP_ASSERT(a_stereo_mode, !hdr_valid || channel_mode == 2'd0 || channels == 4'd2, "bad mode")

endmodule

bind flac_frame_header_parser_core flac_fhp_checker u_fhp_checker (.*);

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench for flac_frame_header_parser_core: header bytes in, one decoded header or error out.
// Depends on flac_fhp_pkg for the status codes, block and rate codes and the parse phase enum.
module tb;
	import flac_fhp_pkg::*;

	localparam int QUIET_LIMIT = 3000;
	localparam int HOLD_CYCLES = 400;

	typedef struct packed {
		logic [3:0]  status;
		logic        variable_size;
		logic [3:0]  channels;
		logic [1:0]  channel_mode;
		logic [4:0]  bits_per_sample;
		logic [35:0] number;
		logic [16:0] block_size;
		logic [19:0] rate_hz;
	} hdr_fields_t;

	typedef enum int {
		F_NONE, F_SYNC0, F_SYNC1, F_BLOCK, F_RATE, F_CHAN,
		F_SIZE, F_RESV, F_LEAD, F_CONT, F_CRC
	} frame_fault_t;

	class header_scoreboard;
		phase_t      phase;
		bit [7:0]    crc;
		bit [3:0]    bcode;
		bit [3:0]    rcode;
		bit [35:0]   num;
		bit [2:0]    left;
		bit          vs;
		bit [3:0]    ch;
		bit [1:0]    cm;
		bit [4:0]    bps;
		bit [15:0]   rawb;
		bit [15:0]   rawr;
		hdr_fields_t expected_headers[$];
		int          mismatches;

		function new();
			phase = PH_IDLE;
			mismatches = 0;
		endfunction

		// Serial form of the CRC-8 with polynomial 0x07, one input bit per step.
		static function bit [7:0] crc_next(bit [7:0] c, bit [7:0] b);
			bit fb;
			for (int i = 7; i >= 0; i--) begin
				fb = c[7] ^ b[i];
				c = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
			end
			return c;
		endfunction

		function string describe(hdr_fields_t h);
			return $sformatf("st=%0d vs=%0d ch=%0d mode=%0d bps=%0d num=%0h bs=%0d rate=%0d",
				h.status, h.variable_size, h.channels, h.channel_mode,
				h.bits_per_sample, h.number, h.block_size, h.rate_hz);
		endfunction

		function void finish_header(bit [3:0] st);
			hdr_fields_t e;
			e = '0;
			e.status = st;
			if (st == ST_OK) begin
				e.variable_size = vs;
				e.channels = ch;
				e.channel_mode = cm;
				e.bits_per_sample = bps;
				e.number = num;
				if (bcode == BC_8BIT || bcode == BC_16BIT)
					e.block_size = {1'b0, rawb} + 17'd1;
				else begin
					case (bcode)
						4'd1:    e.block_size = 17'd192;
						4'd2:    e.block_size = 17'd576;
						4'd3:    e.block_size = 17'd1152;
						4'd4:    e.block_size = 17'd2304;
						4'd5:    e.block_size = 17'd4608;
						4'd0:    e.block_size = 17'd0;
						default: e.block_size = 17'(32'd256 << (bcode - 4'd8));
					endcase
				end
				case (rcode)
					4'd0:    e.rate_hz = 20'd0;
					4'd1:    e.rate_hz = 20'd88200;
					4'd2:    e.rate_hz = 20'd176400;
					4'd3:    e.rate_hz = 20'd192000;
					4'd4:    e.rate_hz = 20'd8000;
					4'd5:    e.rate_hz = 20'd16000;
					4'd6:    e.rate_hz = 20'd22050;
					4'd7:    e.rate_hz = 20'd24000;
					4'd8:    e.rate_hz = 20'd32000;
					4'd9:    e.rate_hz = 20'd44100;
					4'd10:   e.rate_hz = 20'd48000;
					4'd11:   e.rate_hz = 20'd96000;
					RC_KHZ:  e.rate_hz = 20'(32'(rawr) * 32'd1000);
					RC_HZ:   e.rate_hz = 20'(rawr);
					default: e.rate_hz = 20'(32'(rawr) * 32'd10);
				endcase
			end
			expected_headers.push_back(e);
			phase = PH_IDLE;
		endfunction

		function void to_rate_fields();
			if (rcode == RC_KHZ)
				phase = PH_SR_LO;
			else if (rcode == RC_HZ || rcode == RC_10HZ)
				phase = PH_SR_HI;
			else
				phase = PH_CRC;
		endfunction

		// Block size is checked before the rate code once the number is complete.
		function void number_done();
			if (bcode == BC_INVALID)
				finish_header(ST_BLOCKSIZE);
			else if (rcode == RC_INVALID)
				finish_header(ST_RATE);
			else if (bcode == BC_8BIT)
				phase = PH_BS_LO;
			else if (bcode == BC_16BIT)
				phase = PH_BS_HI;
			else
				to_rate_fields();
		endfunction

		function void note_byte(bit [7:0] b, bit fs);
			int n;
			bit [3:0] m;
			if (fs) begin
				bcode = 4'd0;
				rcode = 4'd0;
				num = '0;
				left = '0;
				vs = 1'b0;
				ch = '0;
				cm = '0;
				bps = '0;
				rawb = '0;
				rawr = '0;
				crc = crc_next(8'h00, b);
				if (b != SYNC_BYTE0)
					finish_header(ST_SYNC);
				else
					phase = PH_SYNC1;
				return;
			end
			if (phase == PH_IDLE)
				return;
			crc = crc_next(crc, b);
			case (phase)
				PH_SYNC1: begin
					if (b[7:1] != SYNC_BYTE1)
						finish_header(ST_SYNC);
					else begin
						vs = b[0];
						phase = PH_CODES;
					end
				end
				PH_CODES: begin
					bcode = b[7:4];
					rcode = b[3:0];
					phase = PH_CHAN;
				end
				PH_CHAN: begin
					m = b[7:4];
					if (m >= 4'd11)
						finish_header(ST_CHAN_MODE);
					else if (b[3:1] == 3'd3 || b[3:1] == 3'd7)
						finish_header(ST_SAMPLE_SZ);
					else if (b[0])
						finish_header(ST_PADDING);
					else begin
						ch = (m < 4'd8) ? m + 4'd1 : 4'd2;
						cm = (m < 4'd8) ? 2'd0 : 2'(m - 4'd7);
						case (b[3:1])
							3'd1:    bps = 5'd8;
							3'd2:    bps = 5'd12;
							3'd4:    bps = 5'd16;
							3'd5:    bps = 5'd20;
							3'd6:    bps = 5'd24;
							default: bps = 5'd0;
						endcase
						phase = PH_LEAD;
					end
				end
				PH_LEAD: begin
					if (b[7:6] == 2'b10 || b == 8'hFF)
						finish_header(ST_UTF8);
					else if (!b[7]) begin
						num = 36'(b);
						number_done();
					end else begin
						n = 0;
						while (n < 8 && b[7 - n])
							n++;
						n--;
						num = 36'(b & 8'((1 << (6 - n)) - 1));
						left = 3'(n);
						phase = PH_CONT;
					end
				end
				PH_CONT: begin
					if (b[7:6] != 2'b10)
						finish_header(ST_UTF8);
					else begin
						num = {num[29:0], b[5:0]};
						left = left - 3'd1;
						if (left == 3'd0)
							number_done();
					end
				end
				PH_BS_HI: begin
					rawb = {b, 8'h00};
					phase = PH_BS_LO;
				end
				PH_BS_LO: begin
					rawb = rawb | {8'h00, b};
					to_rate_fields();
				end
				PH_SR_HI: begin
					rawr = {b, 8'h00};
					phase = PH_SR_LO;
				end
				PH_SR_LO: begin
					rawr = rawr | {8'h00, b};
					phase = PH_CRC;
				end
				default: finish_header((crc != 8'h00) ? ST_CRC : ST_OK);
			endcase
		endfunction

		function void check_header(hdr_fields_t got);
			hdr_fields_t e;
			if (expected_headers.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("header result with none expected: %s", describe(got));
				return;
			end
			e = expected_headers.pop_front();
			if (got.status != e.status || got.variable_size != e.variable_size ||
			    got.channels != e.channels || got.channel_mode != e.channel_mode ||
			    got.bits_per_sample != e.bits_per_sample || got.number != e.number ||
			    got.block_size != e.block_size || got.rate_hz != e.rate_hz) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("header mismatch, expected: %s", describe(e));
					$display("                 actual:   %s", describe(got));
				end
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  data_byte = 8'h00;
	logic        frame_start = 1'b0;
	logic        hdr_valid;
	logic        hdr_stall = 1'b0;
	logic [3:0]  status;
	logic        variable_size;
	logic [3:0]  channels;
	logic [1:0]  channel_mode;
	logic [4:0]  bits_per_sample;
	logic [35:0] frame_or_sample_number;
	logic [16:0] block_size;
	logic [19:0] rate_hz;

	header_scoreboard sb;
	hdr_fields_t      seen;
	bit [7:0]         frame_bytes[$];
	int               bytes_sent = 0;
	int               send_idle_pct = 0;
	int               stall_pct = 0;
	int               quiet_cycles = 0;
	bit               hold_req = 1'b0;
	bit               hold_taken = 1'b0;
	int               hold_left = 0;

	flac_frame_header_parser_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.data_byte(data_byte),
		.frame_start(frame_start),
		.hdr_valid(hdr_valid),
		.hdr_stall(hdr_stall),
		.status(status),
		.variable_size(variable_size),
		.channels(channels),
		.channel_mode(channel_mode),
		.bits_per_sample(bits_per_sample),
		.frame_or_sample_number(frame_or_sample_number),
		.block_size(block_size),
		.rate_hz(rate_hz)
	);

	always #6 clk = ~clk;

	// The result side stalls at random, apart from one long hold-off that lets the block fill.
	always @(posedge clk) begin
		if (hold_req && !hold_taken) begin
			hold_taken <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hdr_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			hdr_stall <= 1'b1;
		end else
			hdr_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (hdr_valid && !hdr_stall) begin
				seen.status = status;
				seen.variable_size = variable_size;
				seen.channels = channels;
				seen.channel_mode = channel_mode;
				seen.bits_per_sample = bits_per_sample;
				seen.number = frame_or_sample_number;
				seen.block_size = block_size;
				seen.rate_hz = rate_hz;
				sb.check_header(seen);
			end
			if (byte_valid && !byte_stall)
				sb.note_byte(data_byte, frame_start);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_valid && !byte_stall) || (hdr_valid && !hdr_stall))
				quiet_cycles <= 0;
			else if (quiet_cycles == QUIET_LIMIT) begin
				$display("tb failed");
				$finish;
			end else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic send_byte(input bit [7:0] b, input bit fs);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		data_byte <= b;
		frame_start <= fs;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(input int count);
		for (int i = 0; i < count; i++)
			send_byte(frame_bytes[i], i == 0);
	endtask

	// Builds a well-formed header with a k byte number and a closing CRC byte.
	task automatic build_header(input bit vs, input bit [3:0] bc, input bit [3:0] rc,
			input bit [3:0] chan, input bit [2:0] code, input bit resv, input int k,
			input bit [35:0] value, input bit [15:0] rawb, input bit [15:0] rawr);
		bit [7:0] c;
		bit [7:0] lead;
		frame_bytes.delete();
		frame_bytes.push_back(SYNC_BYTE0);
		frame_bytes.push_back({SYNC_BYTE1, vs});
		frame_bytes.push_back({bc, rc});
		frame_bytes.push_back({chan, code, resv});
		if (k == 1)
			frame_bytes.push_back({1'b0, value[6:0]});
		else begin
			lead = 8'(8'hFF << (8 - k));
			lead = lead | 8'(value >> (6 * (k - 1)));
			frame_bytes.push_back(lead);
			for (int i = k - 2; i >= 0; i--)
				frame_bytes.push_back({2'b10, 6'(value >> (6 * i))});
		end
		if (bc == BC_16BIT)
			frame_bytes.push_back(rawb[15:8]);
		if (bc == BC_8BIT || bc == BC_16BIT)
			frame_bytes.push_back(rawb[7:0]);
		if (rc == RC_HZ || rc == RC_10HZ)
			frame_bytes.push_back(rawr[15:8]);
		if (rc == RC_KHZ || rc == RC_HZ || rc == RC_10HZ)
			frame_bytes.push_back(rawr[7:0]);
		c = 8'h00;
		foreach (frame_bytes[i])
			c = header_scoreboard::crc_next(c, frame_bytes[i]);
		frame_bytes.push_back(c);
	endtask

	function automatic bit [15:0] field16();
		case ($urandom_range(3))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Mostly well-formed headers with random content; the rest carry one fault each.
	task automatic random_frame();
		bit           vs;
		bit [3:0]     bc;
		bit [3:0]     rc;
		bit [3:0]     chan;
		bit [2:0]     code;
		bit           resv;
		int           k;
		int           nbits;
		bit [35:0]    mask;
		bit [35:0]    value;
		bit [7:0]     b;
		frame_fault_t fault;
		vs = 1'($urandom_range(1));
		bc = 4'($urandom_range(1, 15));
		rc = 4'($urandom_range(0, 14));
		chan = 4'($urandom_range(0, 10));
		code = 3'($urandom_range(7));
		while (code == 3'd3 || code == 3'd7)
			code = 3'($urandom_range(7));
		resv = 1'b0;
		k = $urandom_range(1, 7);
		nbits = (k == 1) ? 7 : (7 - k) + 6 * (k - 1);
		mask = (36'h1 << nbits) - 36'h1;
		case ($urandom_range(3))
			0:       value = '0;
			1:       value = mask;
			default: value = 36'({$urandom, $urandom}) & mask;
		endcase
		fault = F_NONE;
		if ($urandom_range(99) < 30)
			fault = frame_fault_t'($urandom_range(1, 10));
		case (fault)
			F_BLOCK: bc = BC_INVALID;
			F_RATE:  rc = RC_INVALID;
			F_CHAN:  chan = 4'($urandom_range(11, 15));
			F_SIZE:  code = $urandom_range(1) ? 3'd3 : 3'd7;
			F_RESV:  resv = 1'b1;
			default: ;
		endcase
		build_header(vs, bc, rc, chan, code, resv, k, value, field16(), field16());
		case (fault)
			F_SYNC0: frame_bytes[0] = 8'($urandom_range(0, 254));
			F_SYNC1: begin
				b = 8'($urandom);
				while (b[7:1] == SYNC_BYTE1)
					b = 8'($urandom);
				frame_bytes[1] = b;
			end
			F_LEAD: frame_bytes[4] = $urandom_range(1) ? 8'hFF : {2'b10, 6'($urandom)};
			F_CONT: begin
				if (k > 1) begin
					b = 8'($urandom);
					if (b[7:6] == 2'b10)
						b[7] = 1'b0;
					frame_bytes[5 + $urandom_range(0, k - 2)] = b;
				end
			end
			F_CRC: frame_bytes[frame_bytes.size() - 1] ^= 8'($urandom_range(1, 255));
			default: ;
		endcase
	endtask

	task automatic run_phase(input int idle_pct, input int stall, input int nbytes);
		int stop;
		int count;
		send_idle_pct = idle_pct;
		stall_pct <= stall;
		stop = bytes_sent + nbytes;
		while (bytes_sent < stop) begin
			// Stray bytes without a frame start, ignored or parsed depending on the phase.
			if ($urandom_range(99) < 8)
				send_byte(8'($urandom), 1'b0);
			random_frame();
			count = frame_bytes.size();
			if ($urandom_range(99) < 8)
				count = $urandom_range(1, count - 1);
			send_frame(count);
		end
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Zero first byte, an ignored byte while idle, then a broken second sync byte.
		send_byte(8'h00, 1'b1);
		send_byte(8'hA5, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFC, 1'b0);
		// A header cut short by a new frame start, then the largest fields of every kind.
		build_header(1'b0, 4'd1, 4'd9, 4'd1, 3'd4, 1'b0, 1, 36'd5, 16'h0000, 16'h0000);
		send_frame(3);
		build_header(1'b1, BC_16BIT, RC_10HZ, 4'd10, 3'd6, 1'b0, 7, '1, 16'hFFFF, 16'hFFFF);
		send_frame(frame_bytes.size());

		hold_req <= 1'b1;
		run_phase(0, 0, 225);
		run_phase(80, 0, 225);
		run_phase(0, 80, 225);
		run_phase(18, 18, 225);
		byte_valid <= 1'b0;

		while (sb.expected_headers.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_headers.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end
endmodule
